// ===== hw/rtl/isl_pkg.sv =====
// Shared constants, payload types and codes for the shear line resampler.
package isl_pkg;

  // Line buffer geometry and pixel width
  localparam int LINE_MAX   = 1024;
  localparam int PIXEL_BITS = 16;
  localparam int ADDR_W     = $clog2(LINE_MAX);

  // Field widths fixed by the item formats
  localparam int POS_W     = 12;
  localparam int LIDX_W    = 10;
  localparam int SF_W      = 16;
  localparam int CNT_W     = 11;
  localparam int BG_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Internal arithmetic widths
  localparam int VAL_W  = (PIXEL_BITS > BG_W) ? PIXEL_BITS : BG_W;
  localparam int MUL_W  = VAL_W + 1;
  localparam int SW     = 14;   // signed positions, steps and lengths
  localparam int D2_W   = 13;   // doubled distance from window center
  localparam int DISP_W = 29;   // shear times doubled distance
  localparam int M_W    = 28;   // displacement magnitude
  localparam int FRAC_W = 16;   // blend weight, Q0.16

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LCOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LLEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd3;

  typedef struct packed {
    logic                         op;
    logic [LIDX_W-1:0]            line_index;
    logic signed [POS_W-1:0]      position;
    logic signed [PIXEL_BITS-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] value;
    logic                         written;
  } out_item_t;

endpackage

// ===== hw/rtl/isl_line_ram.sv =====
// Single-port line buffer with registered read data.
module isl_line_ram
  import isl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [PIXEL_BITS-1:0] wdata_i,
  output logic [PIXEL_BITS-1:0] rdata_o
);

  logic [PIXEL_BITS-1:0] mem [LINE_MAX];
  logic [PIXEL_BITS-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/image_shear_line_resample.sv =====
// Top level of the shear line resampler: sequencer, shared multiplier, output register.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    in_item_i  (in_item_t)
//   out       output     out_valid_o / out_ready_i  out_item_o (out_item_t)
//   cfg       input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A load transfer yields no result and leaves the block ready. A query keeps the
// block busy until its result is loaded: one multiplier is used twice (displacement, then blend) and
// the single-port line buffer is read twice, once per neighbor pixel.
// Reset restores the configuration, sequencer and output valid defaults; the line buffer is not cleared.
// When the output register is still full, the block holds in its last step.
module image_shear_line_resample
  import isl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ABS   = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_RDA   = 3'd4;
  localparam logic [2:0] S_RDB   = 3'd5;
  localparam logic [2:0] S_PROD  = 3'd6;
  localparam logic [2:0] S_BLEND = 3'd7;

  localparam int PROD_W = 2 * MUL_W;
  localparam logic signed [SW-1:0] LINE_MAX_S = SW'(LINE_MAX);

  logic [2:0] state_q, state_d;

  // Configuration registers, held in effective form
  logic signed [SF_W-1:0] shear_q;
  logic [CNT_W-1:0]       cnt_m1_q;
  logic signed [SW-1:0]   len_q;
  logic signed [BG_W-1:0] bg_q;
  logic [CNT_W-1:0]       cfg_raw;
  logic [CNT_W-1:0]       cnt_m1_cfg;
  logic [SW-1:0]          ll_ext;
  logic signed [SW-1:0]   len_cfg;

  // Datapath registers
  logic signed [POS_W-1:0]  p_q;
  logic signed [D2_W-1:0]   d2_q;
  logic signed [D2_W-1:0]   d2_d;
  logic signed [PROD_W-1:0] prod_q;
  logic [M_W-1:0]           m_q;
  logic                     neg_q;
  logic                     nz_q;
  logic [FRAC_W-1:0]        w_q;
  logic signed [SW-1:0]     qa_q, qb_q;
  logic                     wr_q;
  logic                     ina_q, inb_q;
  logic signed [VAL_W-1:0]  a_q, b_q;

  // Handshake and output register
  logic      in_fire;
  logic      out_load;
  logic      out_valid_q;
  out_item_t out_item_q;

  // Memory port
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [PIXEL_BITS-1:0] mem_rdata;
  logic signed [VAL_W-1:0] rd_val;
  logic signed [VAL_W-1:0] bg_ext;
  logic signed [SW-1:0]  pos_ext;
  logic                  load_ok;

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d;

  // Address step signals
  logic signed [DISP_W-1:0] disp;
  logic [DISP_W-1:0]        mag;
  logic signed [SW-1:0]     step_s, pe, len_m1;
  logic signed [SW-1:0]     neg_lo, pos_hi;
  logic signed [SW-1:0]     qa_d, qb_d;
  logic                     wr_d;
  logic                     ina_d, inb_d;
  logic signed [VAL_W-1:0]  b_cur;
  logic signed [PROD_W-1:0] rnd_sum;
  logic [VAL_W-1:0]         res;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Effective line count and length for config writes
  assign cfg_raw    = cfg_wdata_i[CNT_W-1:0];
  assign cnt_m1_cfg = (cfg_raw == '0) ? '0 : cfg_raw - CNT_W'(1);
  assign ll_ext     = SW'(cfg_raw);
  always_comb begin
    if (cfg_raw == '0) begin
      len_cfg = SW'(1);
    end else if (ll_ext > SW'(LINE_MAX)) begin
      len_cfg = LINE_MAX_S;
    end else begin
      len_cfg = ll_ext;
    end
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shear_q  <= '0;
      cnt_m1_q <= '0;
      len_q    <= SW'(1);
      bg_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SHEAR:  shear_q  <= cfg_wdata_i[SF_W-1:0];
        CFG_LCOUNT: cnt_m1_q <= cnt_m1_cfg;
        CFG_LLEN:   len_q    <= len_cfg;
        CFG_BG:     bg_q     <= cfg_wdata_i[BG_W-1:0];
        default:    ;
      endcase
    end
  end

  // Loads go straight into the line buffer
  assign pos_ext = SW'(in_item_i.position);
  assign load_ok = (pos_ext >= 0) && (pos_ext < LINE_MAX_S);
  assign mem_we  = in_fire && (in_item_i.op == OP_LOAD) && load_ok;

  always_comb begin
    case (state_q)
      S_RDA:   mem_addr = qa_q[ADDR_W-1:0];
      S_RDB:   mem_addr = qb_q[ADDR_W-1:0];
      default: mem_addr = in_item_i.position[ADDR_W-1:0];
    endcase
  end

  isl_line_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (in_item_i.pixel),
    .rdata_o (mem_rdata)
  );

  assign rd_val = VAL_W'($signed(mem_rdata));
  assign bg_ext = VAL_W'(bg_q);

  // Doubled distance of the line from the window center
  assign d2_d = $signed({2'b00, in_item_i.line_index, 1'b0}) - $signed({2'b00, cnt_m1_q});

  // Shared multiplier: displacement first, blend product later
  assign b_cur = inb_q ? rd_val : bg_ext;
  always_comb begin
    if (state_q == S_PROD) begin
      mul_a = MUL_W'(a_q) - MUL_W'(b_cur);
      mul_b = MUL_W'($signed({1'b0, w_q}));
    end else begin
      mul_a = MUL_W'(shear_q);
      mul_b = MUL_W'(d2_q);
    end
  end
  assign prod_d = mul_a * mul_b;

  // Magnitude of displacement
  assign disp = prod_q[DISP_W-1:0];
  assign mag  = disp[DISP_W-1] ? DISP_W'(-disp) : DISP_W'(disp);

  // Source positions and write window
  assign step_s = $signed(SW'(m_q[M_W-1:FRAC_W])) + $signed(SW'(1));
  assign pe     = SW'(p_q);
  assign len_m1 = len_q - $signed(SW'(1));
  assign neg_lo = -step_s;
  assign pos_hi = len_m1 + step_s;
  always_comb begin
    if (neg_q) begin
      wr_d = nz_q && (pe >= neg_lo) && (pe <= len_m1);
      qa_d = pe + step_s;
      qb_d = pe + step_s - $signed(SW'(1));
    end else begin
      wr_d = nz_q && (pe >= 0) && (pe <= pos_hi);
      qa_d = pe - step_s;
      qb_d = pe - step_s + $signed(SW'(1));
    end
    if (!wr_d) begin
      qa_d = pe;
      qb_d = pe;
    end
  end

  assign ina_d = (qa_q >= 0) && (qa_q < len_q);
  assign inb_d = (qb_q >= 0) && (qb_q < len_q);

  // Round half up and add back the near pixel
  assign rnd_sum = prod_q + $signed(PROD_W'(1) << (FRAC_W - 1));
  assign res     = b_q + rnd_sum[VAL_W+FRAC_W-1:FRAC_W];

  assign out_load = (state_q == S_BLEND) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire && (in_item_i.op == OP_QUERY)) state_d = S_MUL;
      S_MUL:   state_d = S_ABS;
      S_ABS:   state_d = S_ADDR;
      S_ADDR:  state_d = S_RDA;
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_PROD;
      S_PROD:  state_d = S_BLEND;
      S_BLEND: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, advanced per step
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        p_q  <= in_item_i.position;
        d2_q <= d2_d;
      end
      S_MUL: prod_q <= prod_d;
      S_ABS: begin
        m_q   <= mag[M_W-1:0];
        neg_q <= disp[DISP_W-1];
        nz_q  <= (disp != '0);
      end
      S_ADDR: begin
        qa_q <= qa_d;
        qb_q <= qb_d;
        wr_q <= wr_d;
        w_q  <= m_q[FRAC_W-1:0];
      end
      S_RDA: ina_q <= ina_d;
      S_RDB: begin
        a_q   <= ina_q ? rd_val : bg_ext;
        inb_q <= inb_d;
      end
      S_PROD: begin
        b_q    <= b_cur;
        prod_q <= prod_d;
      end
      default: ;
    endcase
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.value   <= res[PIXEL_BITS-1:0];
      out_item_q.written <= wr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A query reaches the blend step after its multiply, magnitude, address, read and product steps
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_item_i.op == OP_QUERY) |-> ##7 (state_q == S_BLEND))
    else $error("query did not reach blend step on time");

  // A load leaves the block ready for the next item
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_item_i.op == OP_LOAD) |=> in_ready_o)
    else $error("load made the block busy");

  // A blocked result keeps the block in its blend step
  a_blend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLEND) && out_valid_o && !out_ready_i |=> (state_q == S_BLEND))
    else $error("result dropped while output register full");

  // A new result only comes from the blend step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_BLEND))
    else $error("result appeared without a query");

endmodule
